FILE: rtl/dfr_pkg.sv
// shared constants, codes and types of the delimited frame receiver
package dfr_pkg;

  // frame buffer geometry
  localparam int FRAME_DEPTH = 16;
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = IDX_W + 1;
  localparam int ABORT_W     = 5;
  localparam int CMP_W       = (CNT_W > ABORT_W) ? CNT_W : ABORT_W;
  localparam int FRAME_CAP   = (FRAME_DEPTH < 16) ? FRAME_DEPTH : 16;
  localparam int LEN_W       = 4;
  localparam int BYTE_W      = 8;

  // queue sizes
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

  // register reset values
  localparam logic [BYTE_W-1:0]  HEAD_RST   = 8'h00;
  localparam logic [BYTE_W-1:0]  TAIL_RST   = 8'hFF;
  localparam logic [ABORT_W-1:0] ABORT_RST  = 5'd15;
  localparam logic [BYTE_W-1:0]  RELOAD_RST = 8'd10;

  // item actions
  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_TICK = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_HEAD   = 2'd0,
    REG_TAIL   = 2'd1,
    REG_ABORT  = 2'd2,
    REG_RELOAD = 2'd3
  } cfg_reg_t;

  // command from front to back
  typedef struct packed {
    logic             is_frame;
    logic             read_ok;
    logic [LEN_W-1:0] len;
    logic             bank;
    logic             line_idle;
  } cmd_t;

  // frame buffer write from front
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } memwr_t;

  // status from back to front
  typedef struct packed {
    logic frame_done;
  } back_stat_t;

  // one result item
  typedef struct packed {
    logic              read_ok;
    logic [LEN_W-1:0]  frame_length;
    logic [BYTE_W-1:0] frame_byte;
    logic              last;
    logic              line_idle;
  } res_t;

endpackage

FILE: rtl/dfr_front.sv
// front end: config registers, framing state, idle timer and command issue
module dfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [dfr_pkg::BYTE_W-1:0]  cfg_wdata,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [dfr_pkg::BYTE_W-1:0]  in_rx_byte,
  input  logic                        cmd_full,
  output logic                        cmd_push,
  output dfr_pkg::cmd_t               cmd_data,
  output dfr_pkg::memwr_t             mem_wr,
  input  dfr_pkg::back_stat_t         stat
);

  logic [dfr_pkg::BYTE_W-1:0]  head_r, tail_r, reload_r;
  logic [dfr_pkg::ABORT_W-1:0] abort_r;

  logic                        in_frame_r, in_frame_nxt;
  logic [dfr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        pub_valid_r, pub_valid_nxt;
  logic [dfr_pkg::LEN_W-1:0]   pub_len_r, pub_len_nxt;
  logic [dfr_pkg::BYTE_W-1:0]  idle_cnt_r, idle_cnt_nxt;
  logic                        idle_flag_r, idle_flag_nxt;
  logic                        bank_r, bank_nxt;
  logic                        busy_r, busy_nxt;

  logic                        accept;
  logic [dfr_pkg::CMP_W-1:0]   abort_ext, lim, cnt_ext, cnt_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= dfr_pkg::HEAD_RST;
      tail_r   <= dfr_pkg::TAIL_RST;
      abort_r  <= dfr_pkg::ABORT_RST;
      reload_r <= dfr_pkg::RELOAD_RST;
    end else if (cfg_we) begin
      unique case (dfr_pkg::cfg_reg_t'(cfg_addr))
        dfr_pkg::REG_HEAD:   head_r   <= cfg_wdata;
        dfr_pkg::REG_TAIL:   tail_r   <= cfg_wdata;
        dfr_pkg::REG_ABORT:  abort_r  <= cfg_wdata[dfr_pkg::ABORT_W-1:0];
        dfr_pkg::REG_RELOAD: reload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hold off input while the queue is full or a frame read is in flight
  assign in_full = cmd_full || busy_r;
  assign accept  = in_push && !in_full;

  // effective abort limit
  always_comb begin
    abort_ext = dfr_pkg::CMP_W'(abort_r);
    lim       = (abort_ext > dfr_pkg::CMP_W'(dfr_pkg::FRAME_CAP)) ?
                dfr_pkg::CMP_W'(dfr_pkg::FRAME_CAP) : abort_ext;
    cnt_ext   = dfr_pkg::CMP_W'(cnt_r);
    cnt_inc   = (cnt_ext < dfr_pkg::CMP_W'(dfr_pkg::FRAME_DEPTH)) ?
                cnt_ext + dfr_pkg::CMP_W'(1) : cnt_ext;
  end

  // item classification and state update
  always_comb begin
    in_frame_nxt  = in_frame_r;
    cnt_nxt       = cnt_r;
    pub_valid_nxt = pub_valid_r;
    pub_len_nxt   = pub_len_r;
    idle_cnt_nxt  = idle_cnt_r;
    idle_flag_nxt = idle_flag_r;
    bank_nxt      = bank_r;
    busy_nxt      = busy_r && !stat.frame_done;
    mem_wr.we     = 1'b0;
    mem_wr.addr   = {bank_r, cnt_r[dfr_pkg::IDX_W-1:0]};
    mem_wr.data   = in_rx_byte;
    cmd_push      = accept;
    cmd_data      = '0;
    if (accept) begin
      unique case (in_action)
        dfr_pkg::ACT_BYTE: begin
          idle_cnt_nxt  = reload_r;
          idle_flag_nxt = 1'b0;
          if (!in_frame_r) begin
            if (in_rx_byte == head_r) begin
              in_frame_nxt = 1'b1;
              cnt_nxt      = '0;
            end
          end else if (in_rx_byte == tail_r) begin
            // publish by swapping banks
            in_frame_nxt  = 1'b0;
            pub_valid_nxt = 1'b1;
            pub_len_nxt   = cnt_ext[dfr_pkg::LEN_W-1:0];
            bank_nxt      = !bank_r;
            cnt_nxt       = '0;
          end else begin
            mem_wr.we = (cnt_ext < dfr_pkg::CMP_W'(dfr_pkg::FRAME_DEPTH));
            if (cnt_inc >= lim) begin
              in_frame_nxt = 1'b0;
              cnt_nxt      = '0;
            end else begin
              cnt_nxt = cnt_inc[dfr_pkg::CNT_W-1:0];
            end
          end
          cmd_data.line_idle = 1'b0;
        end
        dfr_pkg::ACT_TICK: begin
          if (!idle_flag_r) begin
            if (idle_cnt_r == '0) begin
              idle_flag_nxt = 1'b1;
            end else begin
              idle_cnt_nxt = idle_cnt_r - 1'b1;
            end
          end
          cmd_data.line_idle = idle_flag_nxt;
        end
        dfr_pkg::ACT_READ: begin
          cmd_data.line_idle = idle_flag_r;
          if (pub_valid_r) begin
            pub_valid_nxt    = 1'b0;
            pub_len_nxt      = '0;
            cmd_data.read_ok = 1'b1;
            cmd_data.len     = pub_len_r;
            cmd_data.bank    = !bank_r;
            if (pub_len_r != '0) begin
              cmd_data.is_frame = 1'b1;
              busy_nxt          = 1'b1;
            end
          end
        end
        default: begin
          cmd_data.line_idle = idle_flag_r;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      cnt_r       <= '0;
      pub_valid_r <= 1'b0;
      pub_len_r   <= '0;
      idle_cnt_r  <= '0;
      idle_flag_r <= 1'b1;
      bank_r      <= 1'b0;
      busy_r      <= 1'b0;
    end else begin
      in_frame_r  <= in_frame_nxt;
      cnt_r       <= cnt_nxt;
      pub_valid_r <= pub_valid_nxt;
      pub_len_r   <= pub_len_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      idle_flag_r <= idle_flag_nxt;
      bank_r      <= bank_nxt;
      busy_r      <= busy_nxt;
    end
  end

endmodule

FILE: rtl/dfr_cmdq.sv
// short command queue between front and back
module dfr_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dfr_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output dfr_pkg::cmd_t head
);

  dfr_pkg::cmd_t                   q_r [dfr_pkg::CMDQ_DEPTH];
  logic [dfr_pkg::CMDQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [dfr_pkg::CMDQ_CNT_W-1:0]  cnt_r;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == dfr_pkg::CMDQ_CNT_W'(dfr_pkg::CMDQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/dfr_back.sv
// back end: frame buffer, read sequencer and result queue
module dfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  dfr_pkg::cmd_t        cmd_head,
  output logic                 cmd_pop,
  input  dfr_pkg::memwr_t      mem_wr,
  output dfr_pkg::back_stat_t  stat,
  output logic                 res_empty,
  input  logic                 res_pop,
  output dfr_pkg::res_t        res_head
);

  logic [dfr_pkg::BYTE_W-1:0]      mem_r [2*dfr_pkg::FRAME_DEPTH];
  logic [dfr_pkg::BYTE_W-1:0]      mem_q_r;
  logic [dfr_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                            b_valid_r;
  logic                            b_mem_r;
  dfr_pkg::res_t                   b_res_r, b_res_nxt, push_res;

  dfr_pkg::res_t                   q_r [dfr_pkg::OUTQ_DEPTH];
  logic [dfr_pkg::OUTQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [dfr_pkg::OUTQ_CNT_W-1:0]  cnt_r;
  logic [dfr_pkg::OUTQ_CNT_W:0]    room_need;
  logic                            can_issue, issue, last_byte, do_pop;
  logic [dfr_pkg::ADDR_W-1:0]      rd_addr;

  // issue only when the result queue can take it with one in flight
  assign room_need = (dfr_pkg::OUTQ_CNT_W+1)'(cnt_r)
                   + (dfr_pkg::OUTQ_CNT_W+1)'(b_valid_r);
  assign can_issue = room_need < (dfr_pkg::OUTQ_CNT_W+1)'(dfr_pkg::OUTQ_DEPTH);
  assign issue     = cmd_valid && can_issue;
  assign last_byte = (dfr_pkg::CMP_W'(idx_r) + dfr_pkg::CMP_W'(1))
                   == dfr_pkg::CMP_W'(cmd_head.len);
  assign rd_addr   = {cmd_head.bank, idx_r};

  // read sequencer
  always_comb begin
    cmd_pop         = 1'b0;
    stat.frame_done = 1'b0;
    idx_nxt         = idx_r;
    b_res_nxt.read_ok      = cmd_head.read_ok;
    b_res_nxt.frame_length = cmd_head.len;
    b_res_nxt.frame_byte   = '0;
    b_res_nxt.last         = 1'b1;
    b_res_nxt.line_idle    = cmd_head.line_idle;
    if (issue) begin
      if (cmd_head.is_frame) begin
        b_res_nxt.last = last_byte;
        if (last_byte) begin
          cmd_pop         = 1'b1;
          stat.frame_done = 1'b1;
          idx_nxt         = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end else begin
        cmd_pop = 1'b1;
      end
    end
  end

  // frame buffer, two banks, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      mem_r[mem_wr.addr] <= mem_wr.data;
    end
    if (issue) begin
      mem_q_r <= mem_r[rd_addr];
    end
  end

  // stage after the buffer read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      b_valid_r <= issue;
      idx_r     <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_res_r <= b_res_nxt;
      b_mem_r <= cmd_head.is_frame;
    end
  end

  // merge buffer data into the result
  always_comb begin
    push_res = b_res_r;
    if (b_mem_r) begin
      push_res.frame_byte = mem_q_r;
    end
  end

  // result queue
  assign res_empty = (cnt_r == '0);
  assign res_head  = q_r[rd_ptr_r];
  assign do_pop    = res_pop && !res_empty;

  always_ff @(posedge clk) begin
    if (b_valid_r) begin
      q_r[wr_ptr_r] <= push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (b_valid_r) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)    rd_ptr_r <= rd_ptr_r + 1'b1;
      if (b_valid_r && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !b_valid_r) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/delimited_frame_receiver.sv
// Receives bytes framed by a head and a tail byte and hands published
// frames out one byte per result item. A byte, tick or read of an empty or
// missing frame gives one result; a read of a frame of n bytes gives n
// results, one per cycle while the result queue has room, paced by the
// single read port of the frame buffer in the back end. While such a read
// is still being sequenced the input shows full. Each result passes the
// command queue, the registered buffer read and the result queue. The frame
// buffer has two banks: publishing a frame swaps them, so no copy is made.
// Buffer contents are not cleared at reset and need none.
module delimited_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_addr,
  input  logic [dfr_pkg::BYTE_W-1:0]  cfg_wdata,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [1:0]                  in_action,
  input  logic [dfr_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_read_ok,
  output logic [dfr_pkg::LEN_W-1:0]   out_frame_length,
  output logic [dfr_pkg::BYTE_W-1:0]  out_frame_byte,
  output logic                        out_last,
  output logic                        out_line_idle
);

  logic                 cmd_push, cmd_full, cmd_pop, cmd_valid;
  dfr_pkg::cmd_t        cmd_data, cmd_head;
  dfr_pkg::memwr_t      mem_wr;
  dfr_pkg::back_stat_t  stat;
  dfr_pkg::res_t        res_head;

  // front end
  dfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_action (in_action),
    .in_rx_byte(in_rx_byte),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_data),
    .mem_wr    (mem_wr),
    .stat      (stat)
  );

  // command queue
  dfr_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_data(cmd_data),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd_head)
  );

  // back end
  dfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_head (cmd_head),
    .cmd_pop  (cmd_pop),
    .mem_wr   (mem_wr),
    .stat     (stat),
    .res_empty(out_empty),
    .res_pop  (out_pop),
    .res_head (res_head)
  );

  // result fields
  assign out_read_ok      = res_head.read_ok;
  assign out_frame_length = res_head.frame_length;
  assign out_frame_byte   = res_head.frame_byte;
  assign out_last         = res_head.last;
  assign out_line_idle    = res_head.line_idle;

endmodule

FILE: rtl/dfr_checker.sv
// port-level checks of the frame receiver and their bind
module dfr_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_empty,
  input  logic                        out_pop,
  input  logic                        out_read_ok,
  input  logic [dfr_pkg::LEN_W-1:0]   out_frame_length,
  input  logic [dfr_pkg::BYTE_W-1:0]  out_frame_byte,
  input  logic                        out_last
);

  // a waiting item holds until it is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_read_ok)
      && $stable(out_frame_byte) && $stable(out_last))
    else $error("waiting result changed");

  // a failed read, byte, tick or unused action gives a lone zero result
  a_plain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_read_ok |-> out_last && out_frame_length == '0
      && out_frame_byte == '0)
    else $error("plain result not zero or not last");

  // an empty frame read is a single result
  a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_read_ok && out_frame_length == '0 |-> out_last
      && out_frame_byte == '0)
    else $error("empty frame read malformed");

  // bytes of one frame read keep the same length
  a_same_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pop && out_read_ok && !out_last ##1 !out_empty
      |-> out_read_ok && out_frame_length == $past(out_frame_length))
    else $error("frame read broken up");

endmodule

bind delimited_frame_receiver dfr_checker u_dfr_checker (.*);

FILE: verif/tb.sv
// testbench for delimited_frame_receiver: directed, back-pressure and random frame traffic
`timescale 1ns / 1ps

module tb;
  import dfr_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES = 80;
  localparam int         SETTLE      = 8;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [1:0]        cfg_addr;
  logic [BYTE_W-1:0] cfg_wdata;
  logic              in_push;
  logic              in_full;
  logic [1:0]        in_action;
  logic [BYTE_W-1:0] in_rx_byte;
  logic              out_empty;
  logic              out_pop;
  logic              out_read_ok;
  logic [LEN_W-1:0]  out_frame_length;
  logic [BYTE_W-1:0] out_frame_byte;
  logic              out_last;
  logic              out_line_idle;

  delimited_frame_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_rx_byte       (in_rx_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_read_ok      (out_read_ok),
    .out_frame_length (out_frame_length),
    .out_frame_byte   (out_frame_byte),
    .out_last         (out_last),
    .out_line_idle    (out_line_idle)
  );

  // register mirror
  logic [7:0] head_byte;
  logic [7:0] tail_byte;
  logic [4:0] abort_len;
  logic [7:0] idle_reload;

  // receiver state mirror
  logic       in_frame;
  logic [4:0] collect_count;
  logic [7:0] collect_store [FRAME_DEPTH];
  logic [7:0] pub_store     [FRAME_DEPTH];
  logic [3:0] pub_len;
  logic       pub_valid;
  logic [7:0] idle_count;
  logic       idle_flag;

  res_t due_results[$];
  res_t want;
  int   mismatches;
  bit   gaps_on;
  bit   hold_req;

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // run limit
  initial begin
    #10_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    mismatches++;
    $display("mismatch %s: got %0d, want %0d at %0t", what, got, exp_val, $realtime);
  endtask

  // effective abort limit
  function automatic int frame_limit();
    return (abort_len > FRAME_CAP) ? FRAME_CAP : abort_len;
  endfunction

  function automatic void queue_result(bit ok, logic [3:0] len, logic [7:0] b, bit lst);
    res_t r;
    r.read_ok      = ok;
    r.frame_length = len;
    r.frame_byte   = b;
    r.last         = lst;
    r.line_idle    = idle_flag;
    due_results.push_back(r);
  endfunction

  // advance the mirror by one accepted item and queue what it yields
  function automatic void frame_step(logic [1:0] act, logic [7:0] b);
    int lim;
    int i;
    lim = frame_limit();
    case (act)
      ACT_BYTE: begin
        idle_count = idle_reload;
        idle_flag  = 1'b0;
        if (!in_frame) begin
          if (b == head_byte) begin
            in_frame      = 1'b1;
            collect_count = '0;
          end
        end else if (b == tail_byte) begin
          in_frame      = 1'b0;
          pub_store     = collect_store;
          pub_len       = collect_count[3:0];
          pub_valid     = 1'b1;
          collect_count = '0;
        end else begin
          if (collect_count < FRAME_DEPTH) begin
            collect_store[collect_count] = b;
            collect_count++;
          end
          if (collect_count >= lim) begin
            in_frame      = 1'b0;
            collect_count = '0;
          end
        end
        queue_result(1'b0, 4'd0, 8'd0, 1'b1);
      end
      ACT_TICK: begin
        if (!idle_flag) begin
          if (idle_count == 0) idle_flag = 1'b1;
          else idle_count--;
        end
        queue_result(1'b0, 4'd0, 8'd0, 1'b1);
      end
      ACT_READ: begin
        if (pub_valid) begin
          if (pub_len == 0) begin
            queue_result(1'b1, 4'd0, 8'd0, 1'b1);
          end else begin
            for (i = 0; i < pub_len; i++)
              queue_result(1'b1, pub_len, pub_store[i], i == pub_len - 1);
          end
          pub_valid = 1'b0;
          pub_len   = '0;
        end else begin
          queue_result(1'b0, 4'd0, 8'd0, 1'b1);
        end
      end
      default: queue_result(1'b0, 4'd0, 8'd0, 1'b1);
    endcase
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // offer one item and wait until it is taken
  task automatic push_item(input logic [1:0] act, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push    <= 1'b1;
    in_action  <= act;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    frame_step(act, b);
  endtask

  // stop offering and wait for every due result
  task automatic drain_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_register(input cfg_reg_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HEAD:   head_byte   = val;
      REG_TAIL:   tail_byte   = val;
      REG_ABORT:  abort_len   = val[4:0];
      REG_RELOAD: idle_reload = val;
      default: ;
    endcase
  endtask

  // head, n payload bytes, tail; clean frames never carry the tail early
  task automatic send_frame(input int n, input bit clean);
    logic [7:0] b;
    int k;
    push_item(ACT_BYTE, head_byte);
    for (k = 0; k < n; k++) begin
      b = $urandom_range(0, 255);
      if (b == tail_byte && (clean || $urandom_range(0, 3) != 0)) b = b ^ 8'h01;
      push_item(ACT_BYTE, b);
    end
    push_item(ACT_BYTE, tail_byte);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (due_results.size() == 0) begin
        report_mismatch("item with none due", 1, 0);
      end else begin
        want = due_results.pop_front();
        if (out_read_ok !== want.read_ok)
          report_mismatch("read_ok", out_read_ok, want.read_ok);
        if (out_frame_length !== want.frame_length)
          report_mismatch("frame_length", out_frame_length, want.frame_length);
        if (out_frame_byte !== want.frame_byte)
          report_mismatch("frame_byte", out_frame_byte, want.frame_byte);
        if (out_last !== want.last)
          report_mismatch("last", out_last, want.last);
        if (out_line_idle !== want.line_idle)
          report_mismatch("line_idle", out_line_idle, want.line_idle);
      end
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin : pop_driver
    int n;
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n == 0) begin
          out_pop <= 1'b1;
        end else begin
          out_pop <= 1'b0;
          repeat (n - 1) @(negedge clk);
        end
      end
    end
  end

  // framing with reset registers: ignored bytes, head inside a frame, empty frame
  task automatic test_basic_framing();
    push_item(ACT_TICK, 8'h00);
    push_item(ACT_READ, 8'hFF);
    push_item(ACT_UNUSED, 8'h55);
    push_item(ACT_BYTE, 8'h3C);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_BYTE, 8'hA5);
    push_item(ACT_BYTE, 8'h5A);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_READ, 8'h00);
    push_item(ACT_READ, 8'h00);
    push_item(ACT_BYTE, 8'h00);
    push_item(ACT_BYTE, 8'hFF);
    push_item(ACT_READ, 8'h00);
    drain_results();
  endtask

  // head equal to tail, abort limits of zero and one, zero idle reload
  task automatic test_register_extremes();
    set_register(REG_HEAD, 8'h7E);
    set_register(REG_TAIL, 8'h7E);
    set_register(REG_ABORT, 8'd0);
    set_register(REG_RELOAD, 8'd0);
    push_item(ACT_BYTE, 8'h7E);
    push_item(ACT_BYTE, 8'h81);
    push_item(ACT_BYTE, 8'h7E);
    push_item(ACT_BYTE, 8'h7E);
    push_item(ACT_READ, 8'h00);
    push_item(ACT_TICK, 8'h00);
    drain_results();
    set_register(REG_ABORT, 8'd1);
    push_item(ACT_BYTE, 8'h7E);
    push_item(ACT_BYTE, 8'h42);
    drain_results();
  endtask

  // longest frames while the result side holds off, and a frame cut off at the abort limit
  task automatic test_backpressure();
    set_register(REG_HEAD, 8'hC3);
    set_register(REG_TAIL, 8'h3C);
    set_register(REG_ABORT, 8'd31);
    set_register(REG_RELOAD, 8'd255);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_frame(15, 1'b1);
    push_item(ACT_READ, 8'h00);
    repeat (5) push_item(ACT_TICK, 8'h00);
    drain_results();
    set_register(REG_ABORT, 8'd16);
    send_frame(16, 1'b1);
    push_item(ACT_READ, 8'h00);
    send_frame(15, 1'b1);
    push_item(ACT_READ, 8'h00);
    gaps_on = 1'b1;
    drain_results();
  endtask

  // one random register setting followed by mostly well-formed traffic
  task automatic random_phase(input int n_items);
    int sent;
    int r;
    int len;
    int lim;
    logic [7:0] hb;
    hb = $urandom_range(0, 255);
    set_register(REG_HEAD, hb);
    set_register(REG_TAIL, ($urandom_range(0, 7) == 0) ? hb : 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 70) set_register(REG_ABORT, 8'($urandom_range(4, 16)));
    else if (r < 85) set_register(REG_ABORT, 8'($urandom_range(1, 3)));
    else set_register(REG_ABORT, 8'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (r < 85) set_register(REG_RELOAD, 8'($urandom_range(0, 6)));
    else set_register(REG_RELOAD, 8'($urandom_range(0, 255)));
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      lim = frame_limit();
      if (r < 55) begin
        len = (lim > 1) ? $urandom_range(0, lim - 1) : $urandom_range(0, 2);
        send_frame(len, 1'b0);
        sent += len + 2;
        if ($urandom_range(0, 99) < 80) begin
          push_item(ACT_READ, 8'($urandom_range(0, 255)));
          sent++;
        end
      end else if (r < 70) begin
        len = $urandom_range(1, 8);
        repeat (len) push_item(ACT_TICK, 8'($urandom_range(0, 255)));
        sent += len;
      end else if (r < 80) begin
        push_item(ACT_READ, 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < 92) begin
        push_item(ACT_BYTE, 8'($urandom_range(0, 255)));
        sent++;
      end else if (r < 97) begin
        push_item(ACT_UNUSED, 8'($urandom_range(0, 255)));
        sent++;
      end else begin
        drain_results();
      end
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int p;
    for (p = 0; p < 5; p++) begin
      gaps_on = (p != 2);
      random_phase(10);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_push    = 1'b0;
    in_action  = '0;
    in_rx_byte = '0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    mismatches = 0;
    // reset values of the mirror
    head_byte     = HEAD_RST;
    tail_byte     = TAIL_RST;
    abort_len     = ABORT_RST;
    idle_reload   = RELOAD_RST;
    in_frame      = 1'b0;
    collect_count = '0;
    collect_store = '{default: 8'h00};
    pub_store     = '{default: 8'h00};
    pub_len       = '0;
    pub_valid     = 1'b0;
    idle_count    = '0;
    idle_flag     = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_framing();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dfr_pkg.sv
rtl/dfr_front.sv
rtl/dfr_cmdq.sv
rtl/dfr_back.sv
rtl/delimited_frame_receiver.sv
rtl/dfr_checker.sv
verif/tb.sv
